// ===== hw/rtl/spca_pkg.sv =====
// spca_pkg: shared types and constants of the spike pca projector
// used by spca_front, spca_back and spike_pca_projector_core
`timescale 1ns / 1ps
package spca_pkg;

  localparam int MaxChannels   = 16;
  localparam int MaxWindow     = 64;
  localparam int MaxComponents = 3;
  localparam int MaxWaveLen    = 64;
  localparam int AccW          = 49;
  localparam int TabDepth      = MaxChannels * MaxWindow;
  localparam int TabAw         = $clog2(TabDepth);
  localparam int ChW           = $clog2(MaxChannels);
  localparam int PosW          = $clog2(MaxWindow);
  localparam int CompW         = 2;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_MEAN   = 2'd1,
    REQ_COEF   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_NCH     = 3'd0,
    REG_WLEN    = 3'd1,
    REG_NCOMP   = 3'd2,
    REG_SHIFT   = 3'd3,
    REG_CENTER  = 3'd4,
    REG_PEAK    = 3'd5,
    REG_WAVE    = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_e;

  typedef struct packed {
    req_e               req;
    logic signed [15:0] sample;
    logic [ChW-1:0]     ch;
    logic [PosW-1:0]    pos;
    logic [CompW-1:0]   comp;
    logic signed [23:0] mean;
    logic signed [17:0] coef;
  } item_t;

  typedef struct packed {
    logic [4:0] n_channels;
    logic [6:0] window_len;
    logic [1:0] n_components;
    logic [5:0] rec_shift;
    logic       centered;
    logic       peak_enable;
    logic [6:0] waveform_len;
  } cfg_t;

endpackage

// ===== hw/rtl/spike_pca_projector_core.sv =====
// spike_pca_projector_core: top level with configuration registers
// depends on spca_pkg, spca_front, spca_back
`timescale 1ns / 1ps
// Projects channel-interleaved spike samples onto per-channel eigenvectors.
// Load and out-of-window sample words are taken in the back end's idle
// state; a window sample passes table read, centring, three parallel 18x25
// multiplies and accumulator row read-modify-write in turn, set by the
// single table and accumulator read port. After the spike's last sample
// each channel's row is read and its projections sent, then each peak is
// read and sent; a four-word queue takes input words meanwhile. Writes
// to indices 0-6 clear any spike in progress; no clearing pass follows reset.
module spike_pca_projector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // sample, load_channel, load_position,
                                      // load_component, mean_value, coef_value
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value, channel, component
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import spca_pkg::*;

  cfg_t   cfg_q;
  logic   clr;
  logic   cfg_we;
  logic   item_valid, item_ready;
  item_t  item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign clr         = cfg_we && (reg_e'(cfg_index_i) != REG_UNUSED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n_channels   <= 5'd1;
      cfg_q.window_len   <= 7'd32;
      cfg_q.n_components <= 2'd3;
      cfg_q.rec_shift    <= 6'd0;
      cfg_q.centered     <= 1'b1;
      cfg_q.peak_enable  <= 1'b0;
      cfg_q.waveform_len <= 7'd32;
    end else if (cfg_we) begin
      case (reg_e'(cfg_index_i))
        REG_NCH:    cfg_q.n_channels   <= cfg_data_i[4:0];
        REG_WLEN:   cfg_q.window_len   <= cfg_data_i;
        REG_NCOMP:  cfg_q.n_components <= cfg_data_i[1:0];
        REG_SHIFT:  cfg_q.rec_shift    <= cfg_data_i[5:0];
        REG_CENTER: cfg_q.centered     <= cfg_data_i[0];
        REG_PEAK:   cfg_q.peak_enable  <= cfg_data_i[0];
        REG_WAVE:   cfg_q.waveform_len <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spca_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  spca_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .clr_i         (clr),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/spca_front.sv =====
// spca_front: accepts input words, classifies them and queues them
// depends on spca_pkg
`timescale 1ns / 1ps
module spca_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // sample, load_channel, load_position,
                                              // load_component, mean_value, coef_value
  input  logic [1:0]           s_axis_tuser,  // req_type
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output spca_pkg::item_t      item_o
);
  import spca_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  item_t            queue_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  item_t            cls;
  logic             keep, push, pop;

  // classify: unknown requests and out-of-range coefficient loads are dropped
  always_comb begin
    cls.req    = req_e'(s_axis_tuser);
    cls.sample = $signed(s_axis_tdata[15:0]);
    cls.ch     = s_axis_tdata[19:16];
    cls.pos    = s_axis_tdata[25:20];
    cls.comp   = s_axis_tdata[27:26];
    cls.mean   = $signed(s_axis_tdata[51:28]);
    cls.coef   = $signed(s_axis_tdata[69:52]);
    case (cls.req)
      REQ_SAMPLE, REQ_MEAN: keep = 1'b1;
      REQ_COEF:             keep = (cls.comp < CompW'(MaxComponents));
      default:              keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != (PtrW+1)'(Depth));
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign item_valid_o  = (cnt_q != '0);
  assign pop           = item_valid_o && item_ready_i;
  assign item_o        = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/spca_back.sv =====
// spca_back: table memories, multiply-accumulate sequencer and result output
// depends on spca_pkg
`timescale 1ns / 1ps
module spca_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spca_pkg::cfg_t       cfg_i,
  input  logic                 clr_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  spca_pkg::item_t      item_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // value, channel, component
  output logic                 m_axis_tuser,  // kind
  output logic                 m_axis_tlast
);
  import spca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_ERD, ST_EOUT, ST_PRD, ST_POUT
  } state_e;

  typedef struct packed {
    logic signed [15:0]                    peak;
    logic [MaxComponents-1:0][AccW-1:0]    acc;
  } row_t;

  state_e state_q;

  logic signed [23:0] mean_mem [TabDepth];
  logic signed [17:0] coef_mem [MaxComponents][TabDepth];
  row_t               row_mem  [MaxChannels];

  logic signed [23:0] mean_rd_q;
  logic signed [17:0] coef_rd_q [MaxComponents];
  row_t               row_rd_q;
  logic               rv_q;
  logic [MaxChannels-1:0] row_valid_q;

  logic [ChW-1:0]     ch_q, ec_q;
  logic [6:0]         pos_q;
  logic [CompW-1:0]   ek_q;
  logic signed [15:0] raw_q;
  logic signed [24:0] x_q;
  logic signed [42:0] prod_q [MaxComponents];

  logic               out_valid_q, out_kind_q, out_last_q;
  logic [39:0]        out_data_q;

  logic [4:0]  nch;
  logic [1:0]  ncomp;
  logic [6:0]  wlen, wave, s_full;
  logic        in_win;
  logic [TabAw-1:0] tab_raddr, tab_waddr;
  logic [ChW-1:0]   row_raddr;
  logic        row_we;
  row_t        row_wdata;
  logic [4:0]  ch_inc;
  logic [ChW-1:0] ch_nxt;
  logic [6:0]  pos_nxt;
  logic        slot_free;
  logic        out_load;
  logic signed [AccW-1:0] acc_sel, acc_rnd;
  logic signed [24:0]     proj;
  logic [16:0] abs_raw, abs_cur;
  logic signed [15:0] cur_peak;
  logic        emitting;

  // register limits
  always_comb begin
    nch   = (cfg_i.n_channels == '0) ? 5'd1 :
            (cfg_i.n_channels > 5'(MaxChannels)) ? 5'(MaxChannels) : cfg_i.n_channels;
    ncomp = (cfg_i.n_components == '0) ? 2'd1 : cfg_i.n_components;
    wlen  = (cfg_i.window_len > 7'(MaxWindow)) ? 7'(MaxWindow) : cfg_i.window_len;
    wave  = (cfg_i.waveform_len == '0) ? 7'd1 :
            (cfg_i.waveform_len > 7'(MaxWaveLen)) ? 7'(MaxWaveLen) : cfg_i.waveform_len;
  end

  assign s_full   = pos_q - {1'b0, cfg_i.rec_shift};
  assign in_win   = (pos_q >= {1'b0, cfg_i.rec_shift}) && (s_full < wlen);
  assign tab_raddr = {ch_q, s_full[PosW-1:0]};
  assign tab_waddr = {item_i.ch, item_i.pos};
  assign emitting  = (state_q == ST_ERD) || (state_q == ST_EOUT) ||
                     (state_q == ST_PRD) || (state_q == ST_POUT);
  assign row_raddr = emitting ? ec_q : ch_q;
  assign item_ready_o = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || m_axis_tready;
  assign out_load  = !clr_i && slot_free &&
                     ((state_q == ST_EOUT) || (state_q == ST_POUT));

  assign ch_inc  = {1'b0, ch_q} + 5'd1;
  assign ch_nxt  = (ch_inc >= nch) ? '0 : ch_inc[ChW-1:0];
  assign pos_nxt = (ch_inc >= nch) ? pos_q + 7'd1 : pos_q;

  // accumulate and peak tracking
  always_comb begin
    cur_peak = rv_q ? row_rd_q.peak : 16'sd0;
    abs_raw  = raw_q[15] ? 17'(-{raw_q[15], raw_q}) : {1'b0, raw_q};
    abs_cur  = cur_peak[15] ? 17'(-{cur_peak[15], cur_peak}) : {1'b0, cur_peak};
    row_wdata.peak = (abs_raw > abs_cur) ? raw_q : cur_peak;
    for (int k = 0; k < MaxComponents; k++) begin
      row_wdata.acc[k] = (rv_q ? row_rd_q.acc[k] : '0) +
                         ((k < int'(ncomp)) ? AccW'(prod_q[k]) : '0);
    end
    row_we = (state_q == ST_ACC);
  end

  // projection truncated toward zero
  always_comb begin
    acc_sel = rv_q ? $signed(row_rd_q.acc[ek_q]) : '0;
    acc_rnd = acc_sel + (acc_sel[AccW-1] ? AccW'(24'hFF_FFFF) : '0);
    proj    = acc_rnd[AccW-1:24];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && item_valid_i && (item_i.req == REQ_MEAN)) begin
      mean_mem[tab_waddr] <= item_i.mean;
    end
    if ((state_q == ST_IDLE) && item_valid_i && (item_i.req == REQ_COEF)) begin
      coef_mem[item_i.comp][tab_waddr] <= item_i.coef;
    end
    mean_rd_q <= mean_mem[tab_raddr];
    for (int k = 0; k < MaxComponents; k++) begin
      coef_rd_q[k] <= coef_mem[k][tab_raddr];
    end
    if (row_we) row_mem[ch_q] <= row_wdata;
    row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && item_valid_i) raw_q <= item_i.sample;
    if (state_q == ST_RD) begin
      x_q <= $signed({raw_q[15], raw_q, 8'b0}) -
             (cfg_i.centered ? $signed({mean_rd_q[23], mean_rd_q}) : 25'sd0);
    end
    if (state_q == ST_MUL) begin
      for (int k = 0; k < MaxComponents; k++) prod_q[k] <= coef_rd_q[k] * x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      rv_q        <= 1'b0;
      ch_q        <= '0;
      pos_q       <= '0;
      ec_q        <= '0;
      ek_q        <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      rv_q <= row_valid_q[row_raddr];
      if (out_valid_q && m_axis_tready && !out_load) out_valid_q <= 1'b0;
      if (clr_i) begin
        row_valid_q <= '0;
        ch_q        <= '0;
        pos_q       <= '0;
        state_q     <= ST_IDLE;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (item_valid_i && (item_i.req == REQ_SAMPLE)) begin
              if (in_win) begin
                state_q <= ST_RD;
              end else begin
                ch_q  <= ch_nxt;
                pos_q <= pos_nxt;
                if (pos_nxt >= wave) begin
                  ec_q    <= '0;
                  ek_q    <= '0;
                  state_q <= ST_ERD;
                end
              end
            end
          end
          ST_RD:  state_q <= ST_MUL;
          ST_MUL: state_q <= ST_ACC;
          ST_ACC: begin
            row_valid_q[ch_q] <= 1'b1;
            ch_q  <= ch_nxt;
            pos_q <= pos_nxt;
            if (pos_nxt >= wave) begin
              ec_q    <= '0;
              ek_q    <= '0;
              state_q <= ST_ERD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
          ST_ERD: state_q <= ST_EOUT;
          ST_EOUT: begin
            if (slot_free) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= 1'b0;
              out_data_q  <= {2'b0, ek_q, ec_q, {7{proj[24]}}, proj};
              out_last_q  <= (ek_q == ncomp - 2'd1) &&
                             ({1'b0, ec_q} == nch - 5'd1) && !cfg_i.peak_enable;
              if (ek_q == ncomp - 2'd1) begin
                ek_q <= '0;
                if ({1'b0, ec_q} == nch - 5'd1) begin
                  ec_q <= '0;
                  if (cfg_i.peak_enable) begin
                    state_q <= ST_PRD;
                  end else begin
                    row_valid_q <= '0;
                    ch_q        <= '0;
                    pos_q       <= '0;
                    state_q     <= ST_IDLE;
                  end
                end else begin
                  ec_q    <= ec_q + 1'b1;
                  state_q <= ST_ERD;
                end
              end else begin
                ek_q <= ek_q + 1'b1;
              end
            end
          end
          ST_PRD: state_q <= ST_POUT;
          ST_POUT: begin
            if (slot_free) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= 1'b1;
              out_data_q  <= {2'b0, 2'b0, ec_q, {16{cur_peak[15]}}, cur_peak};
              out_last_q  <= ({1'b0, ec_q} == nch - 5'd1);
              if ({1'b0, ec_q} == nch - 5'd1) begin
                ec_q        <= '0;
                row_valid_q <= '0;
                ch_q        <= '0;
                pos_q       <= '0;
                state_q     <= ST_IDLE;
              end else begin
                ec_q    <= ec_q + 1'b1;
                state_q <= ST_PRD;
              end
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (row_valid_q == '0))
    else $error("rows still valid after clear");

  a_emit_ch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EOUT) |-> (ch_q == '0))
    else $error("channel counter not wrapped during emission");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EOUT || $past(state_q) == ST_POUT))
    else $error("result word loaded outside emission");

endmodule
